// ===== rtl/core/tphc_pkg.sv =====
// tphc_pkg: beat types, constants and the end-around-carry add shared by the
// TCP pseudo-header checksum block. No dependencies.
`timescale 1ns / 1ps

package tphc_pkg;

  localparam logic [15:0] PROTO_TCP = 16'd6;
  localparam logic [15:0] MASK16    = 16'hffff;
  localparam logic [15:0] MASK_HI   = 16'hff00;
  localparam logic [7:0]  MASK8     = 8'hff;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] checksum;
    logic [15:0] segment_length;
  } out_beat_t;

  // finished segment handed from front to back
  typedef struct packed {
    logic [15:0] sum;
    logic [15:0] length;
  } seg_t;

  typedef struct packed {
    logic push;
    logic full;
  } q_ctl_t;

  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

// ===== rtl/core/tphc_front.sv =====
// tphc_front: takes segment bytes, pairs them into words and keeps the running
// sum and byte count. Depends on tphc_pkg.
`timescale 1ns / 1ps

module tphc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  tphc_pkg::in_beat_t in_beat,
  output logic              in_stall,
  input  logic              q_full,
  output logic              q_push,
  output tphc_pkg::seg_t    q_seg
);

  logic [15:0] acc_r, acc_nxt;
  logic [7:0]  held_r, held_nxt;
  logic        odd_r, odd_nxt;
  logic [15:0] count_r, count_nxt;
  logic        accept;
  logic [15:0] word;
  logic [15:0] sum_word;
  logic [15:0] count_inc;

  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;
  // odd trailing byte is padded with a zero low byte
  assign word      = odd_r ? {held_r, in_beat.data_byte}
                           : ({in_beat.data_byte, 8'd0} & tphc_pkg::MASK_HI);
  assign sum_word  = tphc_pkg::oc_add(acc_r, word);
  assign count_inc = count_r + 16'd1;

  assign q_push     = accept && in_beat.last_byte;
  assign q_seg.sum    = sum_word;
  assign q_seg.length = count_inc;

  always_comb begin
    acc_nxt   = acc_r;
    held_nxt  = held_r;
    odd_nxt   = odd_r;
    count_nxt = count_r;
    if (accept) begin
      count_nxt = count_inc;
      if (in_beat.last_byte) begin
        acc_nxt   = 16'd0;
        held_nxt  = 8'd0;
        odd_nxt   = 1'b0;
        count_nxt = 16'd0;
      end else if (odd_r) begin
        acc_nxt  = sum_word;
        held_nxt = 8'd0;
        odd_nxt  = 1'b0;
      end else begin
        held_nxt = in_beat.data_byte & tphc_pkg::MASK8;
        odd_nxt  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= 16'd0;
      held_r  <= 8'd0;
      odd_r   <= 1'b0;
      count_r <= 16'd0;
    end else begin
      acc_r   <= acc_nxt;
      held_r  <= held_nxt;
      odd_r   <= odd_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

// ===== rtl/core/tphc_queue.sv =====
// tphc_queue: small register FIFO of finished segments between front and back.
// Depends on tphc_pkg.
`timescale 1ns / 1ps

module tphc_queue #(
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  tphc_pkg::q_ctl_t ctl_in,
  output logic             full,
  input  tphc_pkg::seg_t   push_seg,
  output logic             pop_valid,
  input  logic             pop_ready,
  output tphc_pkg::seg_t   pop_seg
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  tphc_pkg::seg_t mem [DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic push, pop;

  assign full      = (cnt_r == FULL_CNT);
  assign pop_valid = (cnt_r != '0);
  assign push      = ctl_in.push && !full;
  assign pop       = pop_valid && pop_ready;
  assign pop_seg   = mem[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) wr_nxt = (wr_r == LAST_PTR) ? '0 : wr_r + PTR_W'(1);
    if (pop)  rd_nxt = (rd_r == LAST_PTR) ? '0 : rd_r + PTR_W'(1);
    if (push && !pop) cnt_nxt = cnt_r + CNT_W'(1);
    else if (pop && !push) cnt_nxt = cnt_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_r] <= push_seg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/core/tphc_back.sv =====
// tphc_back: two-stage pipeline adding the link word and length term, then
// the complement into the output register. Depends on tphc_pkg.
`timescale 1ns / 1ps

module tphc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_data,
  input  logic               seg_valid,
  output logic               seg_ready,
  input  tphc_pkg::seg_t     seg,
  output logic               out_valid,
  input  logic               out_stall,
  output tphc_pkg::out_beat_t out_beat,
  output logic               s1_valid
);

  logic [15:0] link_sum_r;
  logic        s1_valid_r;
  logic [15:0] s1_sum_r, s1_len_r, s1_cnt_r;
  logic        s2_valid_r;
  tphc_pkg::out_beat_t s2_r;
  logic s2_take, s1_take;

  assign s2_take   = !s2_valid_r || !out_stall;
  assign s1_take   = !s1_valid_r || s2_take;
  assign seg_ready = s1_take;
  assign out_valid = s2_valid_r;
  assign out_beat  = s2_r;
  assign s1_valid  = s1_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_sum_r <= 16'd0;
    end else if (cfg_we) begin
      link_sum_r <= tphc_pkg::oc_add(cfg_data[31:16], cfg_data[15:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (s1_take) s1_valid_r <= seg_valid;
      if (s2_take) s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take && seg_valid) begin
      s1_sum_r <= tphc_pkg::oc_add(seg.sum, link_sum_r);
      s1_len_r <= seg.length + tphc_pkg::PROTO_TCP;
      s1_cnt_r <= seg.length;
    end
    if (s2_take && s1_valid_r) begin
      s2_r.checksum       <= ~tphc_pkg::oc_add(s1_sum_r, s1_len_r) & tphc_pkg::MASK16;
      s2_r.segment_length <= s1_cnt_r;
    end
  end

endmodule

// ===== rtl/core/tcp_pseudo_header_checksum.sv =====
// Streaming TCP checksum with pseudo-header terms: one byte per beat, one
// result beat per segment, on the byte marked last; a new byte is taken every
// cycle while in_stall is low (the queue is not full), set by the single
// 16-bit end-around-carry add in the front. A result goes from the queue
// entry through the two back stages to out. Under output stall the back holds
// two results and the queue QUEUE_DEPTH more before the input stalls.
// Depends on tphc_pkg, tphc_front, tphc_queue, tphc_back.
`timescale 1ns / 1ps

module tcp_pseudo_header_checksum #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tphc_pkg::in_beat_t  in_beat,
  output logic                out_valid,
  input  logic                out_stall,
  output tphc_pkg::out_beat_t out_beat,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [31:0]         cfg_data
);

  tphc_pkg::q_ctl_t q_ctl;
  tphc_pkg::seg_t   front_seg, back_seg;
  logic q_full, q_push, seg_valid, seg_ready, s1_valid;

  assign cfg_ready  = 1'b1;
  assign q_ctl.push = q_push;
  assign q_ctl.full = q_full;

  tphc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_beat  (in_beat),
    .in_stall (in_stall),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_seg    (front_seg)
  );

  tphc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl_in    (q_ctl),
    .full      (q_full),
    .push_seg  (front_seg),
    .pop_valid (seg_valid),
    .pop_ready (seg_ready),
    .pop_seg   (back_seg)
  );

  tphc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .seg_valid (seg_valid),
    .seg_ready (seg_ready),
    .seg       (back_seg),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat),
    .s1_valid  (s1_valid)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_ctl.push |-> !q_ctl.full)
    else $error("segment pushed into full queue");

  a_s1_held_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid && out_valid && out_stall) |=> s1_valid)
    else $error("back stage dropped a segment under stall");

  a_no_pop_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid && out_valid && out_stall) |-> !seg_ready)
    else $error("queue popped while back pipeline full");

endmodule

// ===== dv/tb_tcp_pseudo_header_checksum.sv =====
// Testbench for tcp_pseudo_header_checksum: streams byte segments under several link
// words and checks every checksum/length beat against an in-bench predictor.
// Depends on tphc_pkg and the tcp_pseudo_header_checksum RTL.
`timescale 1ns / 1ps

module tb_tcp_pseudo_header_checksum;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  tphc_pkg::in_beat_t  in_beat;
  logic                out_valid;
  logic                out_stall;
  tphc_pkg::out_beat_t out_beat;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [31:0]         cfg_data;

  tcp_pseudo_header_checksum uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_beat  (in_beat),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_beat (out_beat),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #2 clk = ~clk;

  // predictor state
  logic [31:0] link_reg  = 32'h0;
  logic [15:0] sum_acc   = 16'h0;
  logic [7:0]  hi_byte   = 8'h0;
  logic        half_full = 1'b0;
  logic [15:0] seg_len   = 16'h0;

  tphc_pkg::in_beat_t  byte_q[$];
  tphc_pkg::out_beat_t csum_q[$];

  bit          idle_on = 1'b1;
  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned hold_left;
  bit          hold_done;
  int unsigned segs_checked = 0;
  int unsigned bytes_sent = 0;
  int unsigned links_written = 0;
  int unsigned errors = 0;

  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] t;
    t = {1'b0, a} + {1'b0, b};
    return t[15:0] + {15'd0, t[16]};
  endfunction

  task automatic take_byte(input tphc_pkg::in_beat_t b);
    logic [15:0]         s;
    tphc_pkg::out_beat_t r;
    seg_len = seg_len + 16'd1;
    if (half_full) begin
      sum_acc   = ones_add(sum_acc, {hi_byte, b.data_byte});
      hi_byte   = 8'h00;
      half_full = 1'b0;
    end else begin
      hi_byte   = b.data_byte;
      half_full = 1'b1;
    end
    if (b.last_byte) begin
      s = sum_acc;
      if (half_full) s = ones_add(s, {hi_byte, 8'h00});
      s = ones_add(s, link_reg[31:16]);
      s = ones_add(s, link_reg[15:0]);
      s = ones_add(s, seg_len + tphc_pkg::PROTO_TCP);
      r.checksum       = ~s;
      r.segment_length = seg_len;
      csum_q.push_back(r);
      sum_acc   = 16'h0000;
      hi_byte   = 8'h00;
      half_full = 1'b0;
      seg_len   = 16'h0000;
    end
  endtask

  task automatic push_byte(input logic [7:0] d, input logic last);
    tphc_pkg::in_beat_t b;
    b.data_byte = d;
    b.last_byte = last;
    byte_q.push_back(b);
  endtask

  // fill: 0 all ones, 1 all zeros, otherwise random bytes
  task automatic push_seg(input int unsigned len, input int unsigned fill);
    logic [7:0] d;
    for (int unsigned i = 0; i < len; i++) begin
      d = (fill == 0) ? 8'hff : (fill == 1) ? 8'h00 : 8'($urandom_range(0, 255));
      push_byte(d, i == len - 1);
    end
  endtask

  task automatic drain();
    while (byte_q.size() != 0 || in_valid || csum_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_link(input logic [31:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    link_reg = v;
    links_written++;
    cfg_valid <= 1'b0;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_beat  <= '0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        take_byte(in_beat);
        bytes_sent++;
      end
      if (in_valid && in_stall) begin
        in_valid <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (byte_q.size() != 0) begin
        if (idle_on && $urandom_range(0, 5) == 0) begin
          gap_left = $urandom_range(0, 2);
          in_valid <= 1'b0;
        end else begin
          in_beat  <= byte_q.pop_front();
          in_valid <= 1'b1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (csum_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected beat: checksum %h length %0d",
                     out_beat.checksum, out_beat.segment_length);
        end else begin
          tphc_pkg::out_beat_t e;
          e = csum_q.pop_front();
          if (e.checksum !== out_beat.checksum ||
              e.segment_length !== out_beat.segment_length) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: checksum exp %h got %h, length exp %0d got %0d",
                       e.checksum, out_beat.checksum,
                       e.segment_length, out_beat.segment_length);
          end
        end
        segs_checked <= segs_checked + 1;
      end
      if (stall_left > 0) stall_left--;
      else if (idle_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 3);
      out_stall <= (stall_left > 0) || (hold_left > 0);
    end
  end

  // one long output hold so the result queue fills and the input backs up
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && segs_checked >= 40) begin
      hold_left <= 80;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  initial begin
    #400_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int unsigned n;
    int unsigned len;
    logic [31:0] links [6];

    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = 32'h0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed
    write_link(32'h0000_0000);
    push_byte(8'hff, 1'b1);
    push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b1);
    push_byte(8'hff, 1'b0); push_byte(8'hff, 1'b0); push_byte(8'hff, 1'b1);
    push_byte(8'h80, 1'b0); push_byte(8'h01, 1'b0);
    push_byte(8'h7f, 1'b0); push_byte(8'hfe, 1'b1);
    push_byte(8'ha5, 1'b0); push_byte(8'h5a, 1'b0); push_byte(8'h01, 1'b1);
    drain();
    write_link(32'hffff_ffff);
    push_byte(8'hff, 1'b0); push_byte(8'hff, 1'b1);
    push_byte(8'h00, 1'b1);
    push_byte(8'hff, 1'b0); push_byte(8'hf9, 1'b1);
    push_byte(8'h55, 1'b0); push_byte(8'haa, 1'b0);
    push_byte(8'h00, 1'b0); push_byte(8'h80, 1'b1);
    drain();

    // random segments
    links[0] = 32'hffff_0000;
    links[1] = 32'h0000_ffff;
    links[2] = $urandom;
    links[3] = 32'h0001_fffe;
    links[4] = $urandom;
    links[5] = 32'hffff_ffff;
    foreach (links[p]) begin
      write_link(links[p]);
      n = 0;
      while (n < 280) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
        push_seg(len, $urandom_range(0, 5));
        n += len;
      end
      drain();
    end

    // back-to-back stretch with no idle cycles on either side
    idle_on = 1'b0;
    write_link($urandom);
    n = 0;
    while (n < 150) begin
      len = $urandom_range(1, 12);
      push_seg(len, 2);
      n += len;
    end
    drain();

    $display("Checked %0d segments (%0d bytes) across %0d link words, with idle bursts,",
             segs_checked, bytes_sent, links_written);
    $display("one long output hold and a closing back-to-back stretch");
    $display("Mismatch count: %0d", errors);
    if (errors == 0 && csum_q.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/tphc_pkg.sv
rtl/core/tphc_front.sv
rtl/core/tphc_queue.sv
rtl/core/tphc_back.sv
rtl/core/tcp_pseudo_header_checksum.sv
dv/tb_tcp_pseudo_header_checksum.sv
